// ===== sv/pgm_dec_pkg.sv =====
// ----------------------------------------------------------------------------
// pgm_dec_pkg
// shared types and constants of the binary grey-map stream decoder
// ----------------------------------------------------------------------------
package pgm_dec_pkg;

    // dimension width limit: width and height must fit in DIM_BITS bits
    localparam int DIM_BITS = 16;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_WIDTH     = 3'd1;
    localparam logic [2:0] ERR_HEIGHT    = 3'd2;
    localparam logic [2:0] ERR_MAX_LARGE = 3'd3;
    localparam logic [2:0] ERR_NO_DELIM  = 3'd4;
    localparam logic [2:0] ERR_DIM_OVF   = 3'd5;

    // character codes
    localparam logic [7:0] CH_P     = 8'd80;
    localparam logic [7:0] CH_FIVE  = 8'd53;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // largest accepted maximum value and its saturation point
    localparam logic [16:0] MAXV_LIMIT = 17'd65535;
    localparam logic [16:0] MAXV_SAT   = 17'd65536;
    localparam logic [16:0] MAXV_BYTE  = 17'd255;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  gray;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] img_width;
        logic [15:0] img_height;
        logic        two_byte_samples;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    function automatic logic f_is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic f_is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

// ===== sv/pgm_dec_parse.sv =====
// ----------------------------------------------------------------------------
// pgm_dec_parse
// header parser and raster counter, one byte per transaction
// ----------------------------------------------------------------------------
module pgm_dec_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_file_start,
    output logic                 o_res_valid,
    output pgm_dec_pkg::t_result o_res
);
    import pgm_dec_pkg::*;

    localparam int ACC_W  = DIM_BITS + 4;
    localparam int MAXV_W = 21;

    localparam logic [3:0] PH_MAGIC0  = 4'd0;
    localparam logic [3:0] PH_MAGIC1  = 4'd1;
    localparam logic [3:0] PH_PRE_W   = 4'd2;
    localparam logic [3:0] PH_COMMENT = 4'd3;
    localparam logic [3:0] PH_WIDTH   = 4'd4;
    localparam logic [3:0] PH_SEP_H   = 4'd5;
    localparam logic [3:0] PH_HEIGHT  = 4'd6;
    localparam logic [3:0] PH_SEP_M   = 4'd7;
    localparam logic [3:0] PH_MAXV    = 4'd8;
    localparam logic [3:0] PH_RASTER  = 4'd9;
    localparam logic [3:0] PH_IDLE    = 4'd10;

    logic [3:0]          r_phase, n_phase;
    logic [DIM_BITS-1:0] r_width, n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic [16:0]         r_maxv, n_maxv;
    logic                r_wide, n_wide;
    logic [DIM_BITS-1:0] r_col, n_col;
    logic [DIM_BITS-1:0] r_row, n_row;
    logic                r_bis, n_bis;

    // effective state: a file start clears everything first
    logic [3:0]          ph;
    logic [DIM_BITS-1:0] w, h, col, row;
    logic [16:0]         mv;
    logic                wide, bis;

    logic [3:0]          digit;
    logic                ws, dig;
    logic [ACC_W-1:0]    w_next, h_next;
    logic [MAXV_W-1:0]   mv_next;
    logic [DIM_BITS:0]   col_inc, row_inc;

    always_comb begin
        ph   = i_file_start ? PH_MAGIC0 : r_phase;
        w    = i_file_start ? '0 : r_width;
        h    = i_file_start ? '0 : r_height;
        mv   = i_file_start ? '0 : r_maxv;
        wide = i_file_start ? 1'b0 : r_wide;
        col  = i_file_start ? '0 : r_col;
        row  = i_file_start ? '0 : r_row;
        bis  = i_file_start ? 1'b0 : r_bis;

        ws    = f_is_ws(i_data_byte);
        dig   = f_is_digit(i_data_byte);
        digit = 4'(i_data_byte - CH_ZERO);

        // times ten plus digit
        w_next  = (ACC_W'(w) << 3) + (ACC_W'(w) << 1) + ACC_W'(digit);
        h_next  = (ACC_W'(h) << 3) + (ACC_W'(h) << 1) + ACC_W'(digit);
        mv_next = (MAXV_W'(mv) << 3) + (MAXV_W'(mv) << 1) + MAXV_W'(digit);
        col_inc = {1'b0, col} + {{DIM_BITS{1'b0}}, 1'b1};
        row_inc = {1'b0, row} + {{DIM_BITS{1'b0}}, 1'b1};

        n_phase  = ph;
        n_width  = w;
        n_height = h;
        n_maxv   = mv;
        n_wide   = wide;
        n_col    = col;
        n_row    = row;
        n_bis    = bis;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (ph)
            PH_MAGIC0: begin
                if (i_data_byte != CH_P) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_MAGIC;
                    n_phase          = PH_IDLE;
                end else begin
                    n_phase = PH_MAGIC1;
                end
            end
            PH_MAGIC1: begin
                if (i_data_byte != CH_FIVE) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_MAGIC;
                    n_phase          = PH_IDLE;
                end else begin
                    n_phase = PH_PRE_W;
                end
            end
            PH_PRE_W, PH_WIDTH: begin
                if (ws) begin
                    if (ph == PH_WIDTH) begin
                        n_phase = PH_SEP_H;
                    end
                end else if (ph == PH_PRE_W && i_data_byte == CH_HASH) begin
                    n_phase = PH_COMMENT;
                end else if (!dig) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_WIDTH;
                    n_phase          = PH_IDLE;
                end else if (w_next[ACC_W-1:DIM_BITS] != '0) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_DIM_OVF;
                    n_phase          = PH_IDLE;
                end else begin
                    n_width = w_next[DIM_BITS-1:0];
                    n_phase = PH_WIDTH;
                end
            end
            PH_COMMENT: begin
                if (i_data_byte == CH_LF) begin
                    n_phase = PH_PRE_W;
                end
            end
            PH_SEP_H, PH_HEIGHT: begin
                if (ws) begin
                    if (ph == PH_HEIGHT) begin
                        n_phase = PH_SEP_M;
                    end
                end else if (!dig) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_HEIGHT;
                    n_phase          = PH_IDLE;
                end else if (h_next[ACC_W-1:DIM_BITS] != '0) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_DIM_OVF;
                    n_phase          = PH_IDLE;
                end else begin
                    n_height = h_next[DIM_BITS-1:0];
                    n_phase  = PH_HEIGHT;
                end
            end
            PH_SEP_M, PH_MAXV: begin
                if (ws) begin
                    if (ph == PH_MAXV) begin
                        o_res_valid = 1'b1;
                        if (mv > MAXV_LIMIT) begin
                            o_res.kind       = KIND_ERROR;
                            o_res.error_code = ERR_MAX_LARGE;
                            n_phase          = PH_IDLE;
                        end else begin
                            n_wide                 = (mv > MAXV_BYTE);
                            o_res.kind             = KIND_HEADER;
                            o_res.img_width        = 16'(w);
                            o_res.img_height       = 16'(h);
                            o_res.two_byte_samples = (mv > MAXV_BYTE);
                            if (w == '0 || h == '0) begin
                                o_res.last = 1'b1;
                                n_phase    = PH_IDLE;
                            end else begin
                                n_phase = PH_RASTER;
                            end
                        end
                    end
                end else if (!dig) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_HEIGHT;
                    n_phase          = PH_IDLE;
                end else begin
                    // saturate so overflow still reads as too large
                    n_maxv  = (mv_next > MAXV_W'(MAXV_SAT)) ? MAXV_SAT : mv_next[16:0];
                    n_phase = PH_MAXV;
                end
            end
            PH_RASTER: begin
                if (bis) begin
                    n_bis = 1'b0;
                end else begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_PIXEL;
                    o_res.gray  = i_data_byte;
                    o_res.pos_x = 16'(col);
                    o_res.pos_y = 16'(row);
                    n_bis       = wide;
                    if (col_inc == {1'b0, w}) begin
                        n_col = '0;
                        n_row = row_inc[DIM_BITS-1:0];
                        if (row_inc == {1'b0, h}) begin
                            o_res.last = 1'b1;
                            n_phase    = PH_IDLE;
                        end
                    end else begin
                        n_col = col_inc[DIM_BITS-1:0];
                    end
                end
            end
            default: begin
                n_phase = ph;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC0;
            r_width  <= '0;
            r_height <= '0;
            r_maxv   <= '0;
            r_wide   <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_bis    <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_height <= n_height;
            r_maxv   <= n_maxv;
            r_wide   <= n_wide;
            r_col    <= n_col;
            r_row    <= n_row;
            r_bis    <= n_bis;
        end
    end

endmodule

// ===== sv/pgm_binary_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// pgm_binary_stream_decoder
// streaming decoder for binary grey-map (P5) files
// ----------------------------------------------------------------------------
// Feed the file one byte per transaction, with i_file_start high on its first
// byte. The block checks the "P5" magic, skips whitespace and '#' comments
// before the width, parses decimal width, height and maximum value, and after
// the single delimiter byte emits one header result followed by one pixel
// result per sample in raster order (two-byte samples keep their high byte
// and emit on it). Errors are reported once, after which bytes are dropped
// until the next file start; bytes after the last pixel are dropped too.
// Throughput is one byte per clock while input is not stalled: each byte costs
// one pass through the parser's multiply-by-ten/compare logic, whose result is
// registered in the output stage. A two-entry output stage (result register
// plus skid register) lets input continue while a result waits; input stalls
// only when both entries hold results.
// ----------------------------------------------------------------------------
module pgm_binary_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_gray,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [15:0] o_img_width,
    output logic [15:0] o_img_height,
    output logic        o_two_byte_samples,
    output logic [2:0]  o_error_code,
    output logic        o_last
);
    import pgm_dec_pkg::*;

    logic    fire;
    logic    res_valid;
    t_result res;

    // output register and skid register
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    // only stall when the skid entry is occupied
    assign o_in_ready = !r_skid_valid;
    assign fire       = i_in_valid && o_in_ready;

    pgm_dec_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            // output slot frees up: skid drains first, keeps order
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= fire && res_valid;
            end
        end else if (fire && res_valid) begin
            // output stalled: park the new result
            r_skid_valid <= 1'b1;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (fire && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_out.kind;
    assign o_gray             = r_out.gray;
    assign o_pos_x            = r_out.pos_x;
    assign o_pos_y            = r_out.pos_y;
    assign o_img_width        = r_out.img_width;
    assign o_img_height       = r_out.img_height;
    assign o_two_byte_samples = r_out.two_byte_samples;
    assign o_error_code       = r_out.error_code;
    assign o_last             = r_out.last;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the binary grey-map stream decoder
// ----------------------------------------------------------------------------
// Bytes of hand-written and randomly generated P5 files go into the decoder
// over its input channel. Each accepted byte also runs through a behavioral
// parser kept in this bench, and the header, pixel and error records that it
// predicts are queued. Every record taken from the result channel is checked,
// field by field, against the oldest queued one. Both channels idle and stall
// at random, with one long stretch where neither does.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pgm_dec_pkg::*;

    // parser position within a file
    typedef enum logic [3:0] {
        ST_WAIT_P,
        ST_WAIT_5,
        ST_PRE_WIDTH,
        ST_COMMENT,
        ST_WIDTH,
        ST_SEP_HEIGHT,
        ST_HEIGHT,
        ST_SEP_MAX,
        ST_MAX,
        ST_RASTER,
        ST_DONE
    } parse_state_e;

    localparam int unsigned DIM_MAX = (1 << DIM_BITS) - 1;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [7:0]  i_data_byte  = 8'd0;
    logic        i_file_start = 1'b0;
    logic        i_out_ready  = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_gray;
    logic [15:0] o_pos_x;
    logic [15:0] o_pos_y;
    logic [15:0] o_img_width;
    logic [15:0] o_img_height;
    logic        o_two_byte_samples;
    logic [2:0]  o_error_code;
    logic        o_last;

    always #5 i_clk = ~i_clk;

    pgm_binary_stream_decoder i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_file_start       (i_file_start),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_gray             (o_gray),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_img_width        (o_img_width),
        .o_img_height       (o_img_height),
        .o_two_byte_samples (o_two_byte_samples),
        .o_error_code       (o_error_code),
        .o_last             (o_last)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_result     expected_q[$];   // records still owed by the decoder
    logic [7:0]  file_q[$];       // file under construction
    int          error_count = 0;
    int          sent_bytes  = 0; // input transactions so far
    bit          idle_on     = 1'b1;

    // parser copy, starts in its reset state
    parse_state_e pst           = ST_WAIT_P;
    logic [15:0]  acc_width     = '0;
    logic [15:0]  acc_height    = '0;
    logic [16:0]  acc_max       = '0;
    bit           wide_px       = 1'b0;
    bit           low_byte_next = 1'b0;
    int unsigned  cur_col       = 0;
    int unsigned  cur_row       = 0;

    function automatic bit is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic bit is_numeral(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // dimension value after one more decimal digit, unclipped
    function automatic int unsigned dim_digit(input logic [15:0] acc, input logic [7:0] b);
        return 32'(acc) * 32'd10 + 32'(b - CH_ZERO);
    endfunction

    // ------------------------------------------------------------------------
    // behavioral parser: one accepted byte in, at most one record out
    // ------------------------------------------------------------------------
    task automatic decode_byte(input logic [7:0] b, input logic st,
                               output bit hit, output t_result res);
        int unsigned v;
        bit          fail;
        logic [2:0]  code;
        hit  = 1'b0;
        res  = '0;
        fail = 1'b0;
        code = ERR_MAGIC;
        // a file start clears everything and this byte is the first magic byte
        if (st) begin
            pst           = ST_WAIT_P;
            acc_width     = '0;
            acc_height    = '0;
            acc_max       = '0;
            wide_px       = 1'b0;
            low_byte_next = 1'b0;
            cur_col       = 0;
            cur_row       = 0;
        end
        case (pst)
            ST_WAIT_P: begin
                if (b != CH_P) fail = 1'b1;
                else pst = ST_WAIT_5;
            end
            ST_WAIT_5: begin
                if (b != CH_FIVE) fail = 1'b1;
                else pst = ST_PRE_WIDTH;
            end
            ST_COMMENT: begin
                // comment runs up to and including the line feed
                if (b == CH_LF) pst = ST_PRE_WIDTH;
            end
            ST_PRE_WIDTH, ST_WIDTH: begin
                if (is_space(b)) begin
                    if (pst == ST_WIDTH) pst = ST_SEP_HEIGHT;
                end else if (b == CH_HASH && pst == ST_PRE_WIDTH) begin
                    pst = ST_COMMENT;
                end else if (!is_numeral(b)) begin
                    fail = 1'b1;
                    code = ERR_WIDTH;
                end else begin
                    v = dim_digit(acc_width, b);
                    if (v > DIM_MAX) begin
                        fail = 1'b1;
                        code = ERR_DIM_OVF;
                    end else begin
                        acc_width = v[15:0];
                        pst       = ST_WIDTH;
                    end
                end
            end
            ST_SEP_HEIGHT, ST_HEIGHT: begin
                if (is_space(b)) begin
                    if (pst == ST_HEIGHT) pst = ST_SEP_MAX;
                end else if (!is_numeral(b)) begin
                    fail = 1'b1;
                    code = ERR_HEIGHT;
                end else begin
                    v = dim_digit(acc_height, b);
                    if (v > DIM_MAX) begin
                        fail = 1'b1;
                        code = ERR_DIM_OVF;
                    end else begin
                        acc_height = v[15:0];
                        pst        = ST_HEIGHT;
                    end
                end
            end
            ST_SEP_MAX, ST_MAX: begin
                if (is_space(b)) begin
                    // whitespace after the maximum is the single delimiter
                    if (pst == ST_MAX) begin
                        if (acc_max > MAXV_LIMIT) begin
                            fail = 1'b1;
                            code = ERR_MAX_LARGE;
                        end else begin
                            wide_px                = (acc_max > MAXV_BYTE);
                            hit                    = 1'b1;
                            res.kind               = KIND_HEADER;
                            res.img_width          = acc_width;
                            res.img_height         = acc_height;
                            res.two_byte_samples   = wide_px;
                            if (acc_width == 0 || acc_height == 0) begin
                                res.last = 1'b1;
                                pst      = ST_DONE;
                            end else begin
                                pst = ST_RASTER;
                            end
                        end
                    end
                end else if (!is_numeral(b)) begin
                    fail = 1'b1;
                    code = ERR_HEIGHT;
                end else begin
                    // maximum saturates just above the largest legal value
                    v = 32'(acc_max) * 32'd10 + 32'(b - CH_ZERO);
                    if (v > 32'(MAXV_SAT)) v = 32'(MAXV_SAT);
                    acc_max = v[16:0];
                    pst     = ST_MAX;
                end
            end
            ST_RASTER: begin
                if (low_byte_next) begin
                    // low byte of a two-byte sample is dropped
                    low_byte_next = 1'b0;
                end else begin
                    hit           = 1'b1;
                    res.kind      = KIND_PIXEL;
                    res.gray      = b;
                    res.pos_x     = cur_col[15:0];
                    res.pos_y     = cur_row[15:0];
                    low_byte_next = wide_px;
                    cur_col++;
                    if (cur_col >= acc_width) begin
                        cur_col = 0;
                        cur_row++;
                        if (cur_row >= acc_height) begin
                            res.last = 1'b1;
                            pst      = ST_DONE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (fail) begin
            hit            = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = code;
            pst            = ST_DONE;
        end
    endtask

    // ------------------------------------------------------------------------
    // input channel: one transaction per call, optional idle stretch in front
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic st);
        bit      hit;
        t_result res;
        if (idle_on && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_file_start <= st;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // transaction taken at this edge
        sent_bytes++;
        decode_byte(b, st, hit, res);
        if (hit) expected_q.push_back(res);
    endtask

    task automatic send_text(input string s, input bit first);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], first && i == 0);
    endtask

    task automatic send_samples(input int n);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // result channel: random back-pressure and checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= !idle_on || ($urandom_range(0, 99) >= 12);
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, o_kind);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("kind",       16'(want.kind),       16'(o_kind));
                check_field("gray",       16'(want.gray),       16'(o_gray));
                check_field("pos_x",      want.pos_x,           o_pos_x);
                check_field("pos_y",      want.pos_y,           o_pos_y);
                check_field("img_width",  want.img_width,       o_img_width);
                check_field("img_height", want.img_height,      o_img_height);
                check_field("two_byte_samples", 16'(want.two_byte_samples),
                            16'(o_two_byte_samples));
                check_field("error_code", 16'(want.error_code), 16'(o_error_code));
                check_field("last",       16'(want.last),       16'(o_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // file construction helpers
    // ------------------------------------------------------------------------
    function automatic void put_number(input int unsigned v, input int zeros);
        string s;
        s = $sformatf("%0d", v);
        repeat (zeros) file_q.push_back(CH_ZERO);
        for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
    endfunction

    // one whitespace byte of any kind
    function automatic void put_space();
        if ($urandom_range(0, 5) == 0) file_q.push_back(CH_SPACE);
        else file_q.push_back(CH_TAB + 8'($urandom_range(0, 4)));
    endfunction

    function automatic int pick_zeros();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    endfunction

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // small well-formed two-by-two image, extreme grey levels, trailing byte dropped
    task automatic test_minimal_image();
        send_text("P5 2 2 255\012", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    // comments, every whitespace kind, two-byte samples and maximum extremes
    task automatic test_header_forms();
        send_text("P5\011# note\012#\012\0133\015\0121\01465535 ", 1'b1);
        send_samples(6);                        // low byte of every sample dropped
        send_text("P5#\377x\012 1 1 256 ", 1'b1);
        send_samples(2);
        send_text("P5 3 1 0\012", 1'b1);       // zero maximum, one-byte samples
        send_samples(3);
        send_text("P53 1 255 ", 1'b1);          // width right after the magic
        send_samples(3);
        send_text("P5 001 00001 00255\015", 1'b1);
        send_samples(1);
        // empty images report last on the header
        send_text("P5 0 65535 255 ", 1'b1);
        send_text("P5 65535 0 7 ", 1'b1);
        send_text("P5 65535 65535 65535 ", 1'b1);
        send_samples(2);
    endtask

    // every reachable error code, with bytes after each error dropped
    task automatic test_header_errors();
        send_text("Q5 1 1 255 ", 1'b1);
        send_text("P6 1 1 255 ", 1'b1);
        send_text("P5 x", 1'b1);
        send_text("P5 #c\0121a 1 1 ", 1'b1);
        send_text("P5 1 x", 1'b1);
        send_text("P5 1 1x", 1'b1);
        send_text("P5 1 1 2x", 1'b1);
        send_text("P5 1 1 65536 ", 1'b1);
        send_text("P5 1 1 9999999 ", 1'b1);
        send_text("P5 65536 ", 1'b1);
        send_text("P5 1 99999 ", 1'b1);
    endtask

    // file start in the middle of a header and in the middle of a raster
    task automatic test_restart_mid_file();
        send_text("P5 4 4 2", 1'b1);
        send_text("P5 1 1 9\012", 1'b1);
        send_samples(1);
        send_text("P5 2 2 300 ", 1'b1);
        send_samples(3);
        send_text("P5 1 2 255 ", 1'b1);
        send_samples(2);
        send_byte(8'h58, 1'b1);
        send_byte(8'h50, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // random files: mostly well formed, some corrupted, cut short or noise
    // ------------------------------------------------------------------------
    task automatic send_random_file();
        int          mode;
        int          sel;
        int unsigned w;
        int unsigned h;
        int unsigned m;
        int          n;
        int          idx;
        logic [7:0]  c;
        file_q.delete();
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            // noise, sometimes with a file start on a random byte
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return;
        end
        file_q.push_back(CH_P);
        file_q.push_back(CH_FIVE);
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) == 0) begin
                file_q.push_back(CH_HASH);
                repeat ($urandom_range(0, 5)) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_LF) c = CH_SPACE;
                    file_q.push_back(c);
                end
                file_q.push_back(CH_LF);
            end else begin
                put_space();
            end
        end
        sel = $urandom_range(0, 11);
        case (sel)
            0: begin w = $urandom_range(0, DIM_MAX); h = 0; end
            1: begin w = 0; h = $urandom_range(0, DIM_MAX); end
            2: begin w = $urandom_range(DIM_MAX + 1, 99999); h = 1; end
            3: begin w = 2; h = $urandom_range(DIM_MAX + 1, 99999); end
            default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 4); end
        endcase
        put_number(w, pick_zeros());
        repeat ($urandom_range(1, 2)) put_space();
        put_number(h, pick_zeros());
        repeat ($urandom_range(1, 2)) put_space();
        case ($urandom_range(0, 6))
            0: m = 255;
            1: m = $urandom_range(0, 254);
            2: m = 256;
            3: m = $urandom_range(257, 65534);
            4: m = 65535;
            5: m = $urandom_range(65536, 999999);
            default: m = $urandom_range(1, 15);
        endcase
        put_number(m, pick_zeros());
        put_space();
        n = (w <= 6 && h <= 4) ? w * h * ((m > 255) ? 2 : 1) : 0;
        repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) file_q.push_back(8'($urandom_range(0, 255)));
        if (mode == 7) begin
            idx = $urandom_range(0, file_q.size() - 1);
            file_q[idx] = 8'($urandom_range(0, 255));
        end else if (mode == 8) begin
            // cut short, the next file start takes over
            idx = $urandom_range(1, file_q.size());
            while (file_q.size() > idx) void'(file_q.pop_back());
        end
        for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == 0);
    endtask

    task automatic test_random_files();
        while (sent_bytes < 700) begin
            // one long stretch where neither side idles
            idle_on = !((sent_bytes >= 450) && (sent_bytes < 600));
            send_random_file();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_minimal_image();
        test_header_forms();
        test_header_errors();
        test_restart_mid_file();
        test_random_files();
        i_in_valid <= 1'b0;
        // drain, then give a stray record time to show up
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/pgm_dec_pkg.sv
sv/pgm_dec_parse.sv
sv/pgm_binary_stream_decoder.sv
tb/tb_top.sv
